@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the circle tessellator; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define CPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("assertion failed");
// check a property on every edge, reset included
`define CPT_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
  else $error("assertion failed");
`else
`define CPT_ASSERT(lbl, clk, rst_n, prop)
`define CPT_ASSERT_NR(lbl, clk, prop)
`endif

`endif

@@ hdl/cpt_pkg.sv @@
// ---------------------------------------------------------------------------
// cpt_pkg
// Shared types, commands and constants of the circle tessellator.
// ---------------------------------------------------------------------------
package cpt_pkg;

  localparam logic [31:0] PI_Q30    = 32'hC90F_DAA2;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [21:0] TOL_RESET = 22'd2496;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FOLD,
    OP_MUL_F,
    OP_MUL_A,
    OP_SET_A2,
    OP_ST_MUL,
    OP_ST_RECIP,
    OP_ST_QUOT,
    OP_ST_UPD,
    OP_SIN_MUL,
    OP_SIN_SAVE,
    OP_COMBINE,
    OP_TEST_MUL,
    OP_VX_MUL,
    OP_VX_SAVE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] kidx;
    logic [6:0] sides;
    logic [6:0] num;
    logic [5:0] vnum;
    logic       half_phase;
    logic       last;
  } cpt_cmd_t;

  typedef struct packed {
    logic r_le_tol;
    logic test_pass;
  } cpt_sts_t;

  // divisor of each series stage: sine chain first, then cosine chain
  function automatic logic [6:0] stage_div(input logic [3:0] k);
    logic [6:0] d;
    case (k)
      4'd0:    d = 7'd72;
      4'd1:    d = 7'd42;
      4'd2:    d = 7'd20;
      4'd3:    d = 7'd6;
      4'd4:    d = 7'd90;
      4'd5:    d = 7'd56;
      4'd6:    d = 7'd30;
      4'd7:    d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // floor(2^31 / divisor) for each stage
  function automatic logic [30:0] stage_recip(input logic [3:0] k);
    logic [30:0] r;
    case (k)
      4'd0:    r = 31'd29826161;
      4'd1:    r = 31'd51130563;
      4'd2:    r = 31'd107374182;
      4'd3:    r = 31'd357913941;
      4'd4:    r = 31'd23860929;
      4'd5:    r = 31'd38347922;
      4'd6:    r = 31'd71582788;
      4'd7:    r = 31'd178956970;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/circle_polygon_tessellator_top.sv @@
// Takes one circle (radius, centre) at a time and emits the vertices of the
// regular polygon with the fewest sides, 3 up to MAX_SIDES, whose chord
// sagitta stays within sag_tolerance (MAX_SIDES if none does), last vertex
// flagged. Every angle is found by a 32-step bit-serial divider and a series
// sine/cosine evaluated on one shared 32x32 multiplier. A vertex is held back
// while the previous one still waits in the output register.
// ---------------------------------------------------------------------------
// circle_polygon_tessellator_top
// Top level: controller, datapath and configuration port.
// ---------------------------------------------------------------------------
module circle_polygon_tessellator_top #(
  parameter int unsigned MAX_SIDES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [21:0]        cfg_sag_tolerance,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_radius,
  input  logic signed [23:0] in_center_x,
  input  logic signed [23:0] in_center_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [25:0] out_vertex_x,
  output logic signed [25:0] out_vertex_y,
  output logic [5:0]         out_vertex_number,
  output logic [6:0]         out_side_count,
  output logic               out_last_vertex
);
  import cpt_pkg::*;

  cpt_cmd_t cmd;
  cpt_sts_t sts;

  // take configuration writes at any time
  assign cfg_ready = 1'b1;

  cpt_ctrl #(
    .MAX_SIDES(MAX_SIDES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid),
    .cfg_sag_tolerance(cfg_sag_tolerance),
    .in_radius        (in_radius),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_number(out_vertex_number),
    .out_side_count   (out_side_count),
    .out_last_vertex  (out_last_vertex)
  );

endmodule

@@ hdl/cpt_datapath.sv @@
// ---------------------------------------------------------------------------
// cpt_datapath
// Divider, shared multiplier, sine/cosine series and vertex output registers.
// ---------------------------------------------------------------------------
module cpt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [21:0]         cfg_sag_tolerance,
  input  logic [23:0]         in_radius,
  input  logic signed [23:0]  in_center_x,
  input  logic signed [23:0]  in_center_y,
  input  cpt_pkg::cpt_cmd_t   cmd,
  output cpt_pkg::cpt_sts_t   sts,
  output logic signed [25:0]  out_vertex_x,
  output logic signed [25:0]  out_vertex_y,
  output logic [5:0]          out_vertex_number,
  output logic [6:0]          out_side_count,
  output logic                out_last_vertex
);
  import cpt_pkg::*;

  logic [21:0]        tol_r;
  logic [23:0]        rad_r;
  logic signed [23:0] cx_r, cy_r;
  logic [6:0]         rem_r;
  logic [31:0]        quo_r;
  logic [1:0]         quad_r;
  logic               mirror_r;
  logic [29:0]        f_r, a_r, a2_r, x_r, q_r;
  logic [30:0]        t_r, s0_r, co_mag_r, si_mag_r;
  logic               co_neg_r, si_neg_r;
  logic signed [25:0] vx_r;
  logic [63:0]        prod_r;
  logic signed [25:0] vtx_x_r, vtx_y_r;
  logic [5:0]         vnum_r;
  logic [6:0]         sides_r;
  logic               last_r;

  logic [7:0]         div_sh;
  logic               div_ge;
  logic [31:0]        phase;
  logic               fold_mir;
  logic [29:0]        fold_f;
  logic [31:0]        mul_a, mul_b;
  logic               mul_en;
  logic [6:0]         k7;
  logic [36:0]        qk, qdiff;
  logic               qcorr;
  logic [29:0]        qc;
  logic [30:0]        cq, sq;
  logic [55:0]        rnd;
  logic [25:0]        rmag;
  logic signed [25:0] rsgn, vx_nxt, vy_nxt;
  logic               rneg;
  logic [55:0]        test_rhs;

  // one step of restoring division
  assign div_sh = {rem_r, 1'b0};
  assign div_ge = div_sh >= {1'b0, cmd.sides};

  // fold the phase into the first octant
  assign phase    = cmd.half_phase ? {1'b0, quo_r[31:1]} : quo_r;
  assign fold_mir = phase[29:0] > 30'h2000_0000;
  assign fold_f   = fold_mir ? 30'(31'h4000_0000 - {1'b0, phase[29:0]}) : phase[29:0];

  // select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_F: begin
        mul_a = {2'b0, f_r};
        mul_b = PI_Q30;
      end
      OP_MUL_A: begin
        mul_a = {2'b0, prod_r[60:31]};
        mul_b = {2'b0, prod_r[60:31]};
      end
      OP_ST_MUL: begin
        mul_a = {2'b0, a2_r};
        mul_b = {1'b0, t_r};
      end
      OP_ST_RECIP: begin
        mul_a = {2'b0, prod_r[59:30]};
        mul_b = {1'b0, stage_recip(cmd.kidx)};
      end
      OP_SIN_MUL: begin
        mul_a = {2'b0, a_r};
        mul_b = {1'b0, t_r};
      end
      OP_TEST_MUL, OP_VX_MUL: begin
        mul_a = {8'b0, rad_r};
        mul_b = {1'b0, co_mag_r};
      end
      OP_VX_SAVE: begin
        mul_a = {8'b0, rad_r};
        mul_b = {1'b0, si_mag_r};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // correct the reciprocal quotient by at most one
  assign k7    = stage_div(cmd.kidx);
  assign qk    = 37'({7'b0, q_r} * {30'b0, k7});
  assign qdiff = {7'b0, x_r} - qk;
  assign qcorr = qdiff >= {30'b0, k7};
  assign qc    = q_r + {29'b0, qcorr};

  // sine and cosine of the octant angle, mirrored back
  assign cq = mirror_r ? s0_r : t_r;
  assign sq = mirror_r ? t_r : s0_r;

  // round r*|c| half away from zero, apply sign
  assign rnd  = prod_r[55:0] + 56'h0000_0000_2000_0000;
  assign rmag = rnd[55:30];
  assign rneg = (cmd.op == OP_EMIT) ? si_neg_r : co_neg_r;
  assign rsgn = rneg ? -$signed(rmag) : $signed(rmag);
  assign vx_nxt = rsgn + {{2{cx_r[23]}}, cx_r};
  assign vy_nxt = rsgn + {{2{cy_r[23]}}, cy_r};

  // status towards the controller
  assign test_rhs      = {2'b0, 24'(rad_r - {2'b0, tol_r}), 30'b0};
  assign sts.r_le_tol  = rad_r <= {2'b0, tol_r};
  assign sts.test_pass = !(co_neg_r && (co_mag_r != '0)) && (prod_r[55:0] >= test_rhs);

  // hold the tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_sag_tolerance;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (cmd.op)
      OP_LOAD: begin
        rad_r <= in_radius;
        cx_r  <= in_center_x;
        cy_r  <= in_center_y;
      end
      OP_DIV_INIT: begin
        rem_r <= cmd.num;
        quo_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? 7'(div_sh - {1'b0, cmd.sides}) : div_sh[6:0];
        quo_r <= {quo_r[30:0], div_ge};
      end
      OP_FOLD: begin
        quad_r   <= phase[31:30];
        mirror_r <= fold_mir;
        f_r      <= fold_f;
      end
      OP_MUL_A: a_r <= prod_r[60:31];
      OP_SET_A2: begin
        a2_r <= prod_r[59:30];
        t_r  <= ONE_Q30;
      end
      OP_ST_RECIP: x_r <= prod_r[59:30];
      OP_ST_QUOT:  q_r <= prod_r[60:31];
      OP_ST_UPD:   t_r <= ONE_Q30 - {1'b0, qc};
      OP_SIN_SAVE: begin
        s0_r <= prod_r[60:30];
        t_r  <= ONE_Q30;
      end
      OP_COMBINE: begin
        case (quad_r)
          2'd0: begin
            co_mag_r <= cq; co_neg_r <= 1'b0;
            si_mag_r <= sq; si_neg_r <= 1'b0;
          end
          2'd1: begin
            co_mag_r <= sq; co_neg_r <= 1'b1;
            si_mag_r <= cq; si_neg_r <= 1'b0;
          end
          2'd2: begin
            co_mag_r <= cq; co_neg_r <= 1'b1;
            si_mag_r <= sq; si_neg_r <= 1'b1;
          end
          default: begin
            co_mag_r <= sq; co_neg_r <= 1'b0;
            si_mag_r <= cq; si_neg_r <= 1'b1;
          end
        endcase
      end
      OP_VX_SAVE: vx_r <= vx_nxt;
      OP_EMIT: begin
        vtx_x_r <= vx_r;
        vtx_y_r <= vy_nxt;
        vnum_r  <= cmd.vnum;
        sides_r <= cmd.sides;
        last_r  <= cmd.last;
      end
      default: ;
    endcase
  end

  assign out_vertex_x      = vtx_x_r;
  assign out_vertex_y      = vtx_y_r;
  assign out_vertex_number = vnum_r;
  assign out_side_count    = sides_r;
  assign out_last_vertex   = last_r;

endmodule

@@ hdl/cpt_ctrl.sv @@
// ---------------------------------------------------------------------------
// cpt_ctrl
// Sequencer: side search, per-vertex division and series, output handshake.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_ctrl #(
  parameter int unsigned MAX_SIDES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cpt_pkg::cpt_sts_t sts,
  output cpt_pkg::cpt_cmd_t cmd
);
  import cpt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIV_INIT, S_DIV, S_FOLD, S_MUL_F, S_MUL_A, S_SET_A2,
    S_ST_MUL, S_ST_RECIP, S_ST_QUOT, S_ST_UPD, S_SIN_MUL, S_SIN_SAVE,
    S_COMBINE, S_TEST_MUL, S_TEST_CMP, S_VX_MUL, S_VX_SAVE, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] n_r, n_nxt;
  logic [5:0] i_r, i_nxt;
  logic [3:0] kidx_r, kidx_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       test_r, test_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_go, is_last;

  assign emit_go = !out_valid_r || out_ready;
  assign is_last = {1'b0, i_r} == 7'(n_r - 7'd1);

  // next state and command
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    kidx_nxt      = kidx_r;
    cnt_nxt       = cnt_r;
    test_nxt      = test_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op         = OP_NONE;
    cmd.kidx       = kidx_r;
    cmd.sides      = n_r;
    cmd.num        = test_r ? 7'd1 : {1'b0, i_r};
    cmd.vnum       = i_r;
    cmd.half_phase = test_r;
    cmd.last       = is_last;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          n_nxt     = 7'd3;
          i_nxt     = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        test_nxt  = !sts.r_le_tol;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == '1) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.op    = OP_MUL_F;
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op    = OP_MUL_A;
        state_nxt = S_SET_A2;
      end
      S_SET_A2: begin
        cmd.op    = OP_SET_A2;
        kidx_nxt  = '0;
        state_nxt = S_ST_MUL;
      end
      S_ST_MUL: begin
        cmd.op    = OP_ST_MUL;
        state_nxt = S_ST_RECIP;
      end
      S_ST_RECIP: begin
        cmd.op    = OP_ST_RECIP;
        state_nxt = S_ST_QUOT;
      end
      S_ST_QUOT: begin
        cmd.op    = OP_ST_QUOT;
        state_nxt = S_ST_UPD;
      end
      // advance through the sine chain, then the cosine chain
      S_ST_UPD: begin
        cmd.op   = OP_ST_UPD;
        kidx_nxt = kidx_r + 4'd1;
        if (kidx_r == 4'd3) begin
          state_nxt = S_SIN_MUL;
        end else if (kidx_r == 4'd8) begin
          state_nxt = S_COMBINE;
        end else begin
          state_nxt = S_ST_MUL;
        end
      end
      S_SIN_MUL: begin
        cmd.op    = OP_SIN_MUL;
        state_nxt = S_SIN_SAVE;
      end
      S_SIN_SAVE: begin
        cmd.op    = OP_SIN_SAVE;
        state_nxt = S_ST_MUL;
      end
      S_COMBINE: begin
        cmd.op    = OP_COMBINE;
        state_nxt = test_r ? S_TEST_MUL : S_VX_MUL;
      end
      S_TEST_MUL: begin
        cmd.op    = OP_TEST_MUL;
        state_nxt = S_TEST_CMP;
      end
      // take this side count, or try the next one
      S_TEST_CMP: begin
        state_nxt = S_DIV_INIT;
        if (sts.test_pass || (n_r == 7'(MAX_SIDES))) begin
          test_nxt = 1'b0;
        end else begin
          n_nxt = n_r + 7'd1;
        end
      end
      S_VX_MUL: begin
        cmd.op    = OP_VX_MUL;
        state_nxt = S_VX_SAVE;
      end
      S_VX_SAVE: begin
        cmd.op    = OP_VX_SAVE;
        state_nxt = S_EMIT;
      end
      // hold until the output register is free
      S_EMIT: begin
        if (emit_go) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 6'd1;
            state_nxt = S_DIV_INIT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= 7'd3;
      i_r         <= '0;
      kidx_r      <= '0;
      cnt_r       <= '0;
      test_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      kidx_r      <= kidx_nxt;
      cnt_r       <= cnt_nxt;
      test_r      <= test_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  `CPT_ASSERT(a_vtx_in_range, clk, rst_n, {1'b0, i_r} < n_r)
  `CPT_ASSERT(a_sides_range, clk, rst_n, (n_r >= 7'd3) && (n_r <= 7'(MAX_SIDES)))
  `CPT_ASSERT(a_emit_src, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_EMIT))
  `CPT_ASSERT(a_stage_idx, clk, rst_n, (state_r == S_ST_MUL) |-> (kidx_r <= 4'd8))
  `CPT_ASSERT_NR(a_rst_clears, clk, !rst_n |=> ((state_r == S_IDLE) && !out_valid_r))

endmodule

@@ test/circle_polygon_tessellator_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_polygon_tessellator_top_tb
// Drives circles into the tessellator under random gaps and stalls, works out
// every polygon vertex in fixed point alongside the block and compares each
// emitted vertex, field by field, with the oldest one still outstanding.
// ---------------------------------------------------------------------------
module circle_polygon_tessellator_top_tb;

  localparam int unsigned SIDE_LIMIT = 64;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic [5:0]         vnum;
    logic [6:0]         sides;
    logic               last;
  } vertex_t;

  // ------------------------------------------------------------------------
  // Vertex scoreboard: fixed-point polygon predictor and pending vertices
  // ------------------------------------------------------------------------
  class vertex_board;
    vertex_t pending_vertices[$];
    int      mismatches;

    // cosine and sine of a 32-bit phase, Q2.30
    function automatic void turn_trig(input logic [31:0] ph, output longint co,
                                      output longint si);
      longint unsigned f, a, a2, t, u;
      longint          s0, c0, cq, sq;
      logic [1:0]      quad;
      bit              mirror;
      quad   = ph[31:30];
      f      = ph[29:0];
      mirror = f > 64'h2000_0000;
      if (mirror) f = 64'h4000_0000 - f;
      a  = (f * 64'hC90F_DAA2) >> 31;
      a2 = (a * a) >> 30;
      t = 64'h4000_0000;
      t = 64'h4000_0000 - (((a2 * t) >> 30) / 72);
      t = 64'h4000_0000 - (((a2 * t) >> 30) / 42);
      t = 64'h4000_0000 - (((a2 * t) >> 30) / 20);
      t = 64'h4000_0000 - (((a2 * t) >> 30) / 6);
      s0 = longint'((a * t) >> 30);
      u = 64'h4000_0000;
      u = 64'h4000_0000 - (((a2 * u) >> 30) / 90);
      u = 64'h4000_0000 - (((a2 * u) >> 30) / 56);
      u = 64'h4000_0000 - (((a2 * u) >> 30) / 30);
      u = 64'h4000_0000 - (((a2 * u) >> 30) / 12);
      u = 64'h4000_0000 - (((a2 * u) >> 30) / 2);
      c0 = longint'(u);
      cq = mirror ? s0 : c0;
      sq = mirror ? c0 : s0;
      case (quad)
        2'd0: begin co = cq;  si = sq;  end
        2'd1: begin co = -sq; si = cq;  end
        2'd2: begin co = -cq; si = -sq; end
        default: begin co = sq; si = -cq; end
      endcase
    endfunction

    // radius times a Q2.30 factor, rounded half away from zero
    function automatic longint scaled_q22(input longint r, input longint c);
      longint m;
      m = ((r * (c < 0 ? -c : c)) + (64'sd1 <<< 29)) >>> 30;
      return (c < 0) ? -m : m;
    endfunction

    // fewest sides whose sagitta stays within tolerance
    function automatic int pick_side_count(input longint r, input longint tol);
      longint c, s;
      if (r <= tol) return 3;
      for (int n = 3; n <= SIDE_LIMIT; n++) begin
        turn_trig(32'h8000_0000 / n, c, s);
        if (c >= 0 && r * c >= ((r - tol) <<< 30)) return n;
      end
      return SIDE_LIMIT;
    endfunction

    // note an accepted circle: queue every vertex it yields
    function automatic void note_circle(input logic [23:0] radius,
                                        input logic signed [23:0] cx,
                                        input logic signed [23:0] cy,
                                        input logic [21:0] tol);
      int      n;
      longint  c, s, x, y;
      vertex_t v;
      n = pick_side_count(longint'(radius), longint'(tol));
      for (int i = 0; i < n; i++) begin
        turn_trig(32'((longint'(i) <<< 32) / n), c, s);
        x = scaled_q22(longint'(radius), c) + longint'(cx);
        y = scaled_q22(longint'(radius), s) + longint'(cy);
        v.vx    = x[25:0];
        v.vy    = y[25:0];
        v.vnum  = i[5:0];
        v.sides = n[6:0];
        v.last  = (i == n - 1);
        pending_vertices.push_back(v);
      end
    endfunction

    // check an emitted vertex against the oldest pending one
    function automatic void check_vertex(input vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        $error("vertex emitted with none pending");
        mismatches++;
        return;
      end
      want = pending_vertices.pop_front();
      if (got.vx !== want.vx) begin
        $error("vertex_x expected %0d got %0d", want.vx, got.vx); mismatches++;
      end
      if (got.vy !== want.vy) begin
        $error("vertex_y expected %0d got %0d", want.vy, got.vy); mismatches++;
      end
      if (got.vnum !== want.vnum) begin
        $error("vertex_number expected %0d got %0d", want.vnum, got.vnum);
        mismatches++;
      end
      if (got.sides !== want.sides) begin
        $error("side_count expected %0d got %0d", want.sides, got.sides);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_vertex expected %0d got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [21:0]        cfg_sag_tolerance;
  logic               in_valid;
  logic               in_ready;
  logic [23:0]        in_radius;
  logic signed [23:0] in_center_x;
  logic signed [23:0] in_center_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [25:0] out_vertex_x;
  logic signed [25:0] out_vertex_y;
  logic [5:0]         out_vertex_number;
  logic [6:0]         out_side_count;
  logic               out_last_vertex;

  vertex_board board;
  logic [21:0] tolerance_now;
  bit          long_hold_req;
  bit          sink_eager;
  bit          source_eager;

  circle_polygon_tessellator_top #(.MAX_SIDES(SIDE_LIMIT)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sag_tolerance (cfg_sag_tolerance),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_radius         (in_radius),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_x      (out_vertex_x),
    .out_vertex_y      (out_vertex_y),
    .out_vertex_number (out_vertex_number),
    .out_side_count    (out_side_count),
    .out_last_vertex   (out_last_vertex)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one circle, hold it until taken, then drop valid for a random gap, if any
  task automatic send_circle(input logic [23:0] r, input logic [23:0] cx,
                             input logic [23:0] cy);
    int gap;
    in_valid    <= 1'b1;
    in_radius   <= r;
    in_center_x <= cx;
    in_center_y <= cy;
    do @(posedge clk); while (!in_ready);
    board.note_circle(r, cx, cy, tolerance_now);
    gap = source_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the input idle until every pending vertex has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the tolerance register while idle
  task automatic write_tolerance(input logic [21:0] tol);
    wait_drained();
    cfg_valid         <= 1'b1;
    cfg_sag_tolerance <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    tolerance_now = tol;
  endtask

  // radius: mostly small so polygons stay short, sometimes full range
  function automatic logic [23:0] draw_radius();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 24'($urandom_range(0, 16383));
    if (pick < 90) return 24'($urandom_range(0, 262143));
    return 24'($urandom);
  endfunction

  task automatic random_circles(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 30) source_eager = ~source_eager;
      send_circle(draw_radius(), 24'($urandom), 24'($urandom));
    end
  endtask

  // result side: random stalls, eager stretches and one long hold-off
  initial begin
    int hold;
    vertex_t got;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.vx    = out_vertex_x;
        got.vy    = out_vertex_y;
        got.vnum  = out_vertex_number;
        got.sides = out_side_count;
        got.last  = out_last_vertex;
        board.check_vertex(got);
        hold = sink_eager ? 0 : $urandom_range(0, 3);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 4000;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= rst_n;
      end
    end
  end

  // stimulus
  initial begin
    board         = new();
    tolerance_now = 22'd2496;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_sag_tolerance = '0;
    in_valid          = 1'b0;
    in_radius         = '0;
    in_center_x       = '0;
    in_center_y       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes, radius at and just past the tolerance
    send_circle(24'd0, 24'h000000, 24'h000000);
    send_circle(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_circle(24'hFFFFFF, 24'h800000, 24'h800000);
    send_circle(24'd2496, 24'h7FFFFF, 24'h800000);
    send_circle(24'd2497, 24'h800000, 24'h7FFFFF);
    send_circle(24'h400000, 24'hFFFFFF, 24'h000001);
    send_circle(24'h800000, 24'h555555, 24'hAAAAAA);
    send_circle(24'h000100, 24'hAAAAAA, 24'h555555);

    // fill the block against a stalled result side
    long_hold_req = 1'b1;
    source_eager  = 1'b1;
    for (int k = 0; k < 6; k++) send_circle(24'($urandom_range(0, 4095)),
                                            24'($urandom), 24'($urandom));
    source_eager = 1'b0;
    wait_drained();

    random_circles(180);

    // smallest tolerance: large radii saturate, tiny radii stay triangles, keep it short
    write_tolerance(22'd1);
    send_circle(24'd0, 24'h123456, 24'h654321);
    send_circle(24'd1, 24'h000000, 24'h000000);
    send_circle(24'd2, 24'h7FFFFF, 24'h800000);
    random_circles(10);

    // largest tolerance: triangles almost always
    write_tolerance(22'h3FFFFF);
    send_circle(24'h3FFFFF, 24'h000000, 24'h000000);
    send_circle(24'h400000, 24'h000000, 24'h000000);
    send_circle(24'hFFFFFF, 24'h800000, 24'h7FFFFF);
    sink_eager = 1'b1;
    random_circles(60);
    sink_eager = 1'b0;

    write_tolerance(22'($urandom_range(1000, 60000)));
    random_circles(110);

    write_tolerance(22'($urandom));
    random_circles(60);

    write_tolerance(22'd2496);
    random_circles(50);

    wait_drained();
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // end the run if it hangs
  initial begin
    #250_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cpt_pkg.sv
hdl/cpt_datapath.sv
hdl/cpt_ctrl.sv
hdl/circle_polygon_tessellator_top.sv
test/circle_polygon_tessellator_top_tb.sv
